>>> rtl/core/rpn_pkg.sv
// Shared constants, codes and types of the RPN stack evaluator.
`default_nettype none

package rpn_pkg;

    localparam int STACK_DEPTH = 128;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int REQ_W       = 3;
    localparam int STATUS_W    = 2;
    localparam int DIV_STEPS   = DATA_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH   = 3'd0,
        REQ_ADD    = 3'd1,
        REQ_SUB    = 3'd2,
        REQ_MUL    = 3'd3,
        REQ_DIV    = 3'd4,
        REQ_EQUALS = 3'd5
    } req_code_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_DIVZERO   = 2'd3
    } status_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } mem_wr_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/rpn_if.sv
// Request and response channel interfaces of the RPN stack evaluator.
`default_nettype none

interface rpn_req_if;
    import rpn_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [REQ_W-1:0]         req_type;
    logic signed [DATA_W-1:0] operand_value;

    modport source (output valid, output req_type, output operand_value, input ready);
    modport sink   (input valid, input req_type, input operand_value, output ready);
endinterface

interface rpn_rsp_if;
    import rpn_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] result_value;
    logic [STATUS_W-1:0]      status;
    logic                     expression_done;

    modport source (output valid, output result_value, output status,
                    output expression_done, input ready);
    modport sink   (input valid, input result_value, input status,
                    input expression_done, output ready);
endinterface

`default_nettype wire

>>> rtl/core/rpn_stack_evaluator_core.sv
// Top level of the RPN stack evaluator: request sequencer around the stack memory.
// Flow: push, ignored codes and overflow or underflow answers go from idle straight to done;
//   add, subtract, multiply and equals pass through operate; divide (unless by zero) also waits in divide.
// Throughput: one request at a time, so the next request is taken once the sequencer is
//   back in idle after its response moves out; a divide also waits on the 32-step divider.
// Reset: stack count cleared, sequencer idle, response channel empty. Stack contents are
//   undefined after reset; entries at or above the count are never used, so no clearing pass.
`default_nettype none

module rpn_stack_evaluator_core (
    input  wire logic clk,
    input  wire logic rst_n,
    rpn_req_if.sink   req,
    rpn_rsp_if.source rsp
);
    import rpn_pkg::*;

    // one-hot sequencer states
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_OPER = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [REQ_W-1:0]     req_reg, req_next;
    logic [DATA_W-1:0]    res_reg, res_next;
    status_t              status_reg, status_next;
    logic                 done_reg, done_next;
    logic                 wb_reg, wb_next;
    logic                 neg_reg, neg_next;

    logic                 out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]    out_value_reg;
    status_t              out_status_reg;
    logic                 out_done_reg;
    logic                 out_load;

    mem_wr_t              mem_wr;
    logic [ADDR_W-1:0]    rd_addr_a;
    logic [ADDR_W-1:0]    rd_addr_b;
    logic [DATA_W-1:0]    rd_data_a;
    logic [DATA_W-1:0]    rd_data_b;
    logic [DATA_W-1:0]    product;

    logic                 div_start;
    logic [DATA_W-1:0]    mag_a;
    logic [DATA_W-1:0]    mag_b;
    logic [DATA_W-1:0]    quotient;
    div_stat_t            div_stat;

    logic                 stack_full;

    // Port A always reads the top entry, port B the one below it. The count only moves
    // on a push in idle, on an equals in the operate state or on leaving the done state,
    // so the read data is settled by the time the operate state looks at it, and no read
    // that the operate state uses overlaps a write of the same entry.
    assign rd_addr_a  = ADDR_W'(count_reg - CNT_W'(1));
    assign rd_addr_b  = ADDR_W'(count_reg - CNT_W'(2));
    assign stack_full = (count_reg == CNT_W'(STACK_DEPTH));

    rpn_stack_mem u_mem (
        .clk       (clk),
        .wr        (mem_wr),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    // top entry is the right operand, the one below is the left operand
    assign product = rd_data_b * rd_data_a;
    assign mag_a   = rd_data_a[DATA_W-1] ? (DATA_W'(0) - rd_data_a) : rd_data_a;
    assign mag_b   = rd_data_b[DATA_W-1] ? (DATA_W'(0) - rd_data_b) : rd_data_b;

    rpn_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mag_b),
        .divisor  (mag_a),
        .quotient (quotient),
        .stat     (div_stat)
    );

    assign req.ready = (state_reg == S_IDLE);

    // the finished response moves out when the output slot is empty or being drained
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        req_next    = req_reg;
        res_next    = res_reg;
        status_next = status_reg;
        done_next   = done_reg;
        wb_next     = wb_reg;
        neg_next    = neg_reg;
        div_start   = 1'b0;
        mem_wr      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    req_next    = req.req_type;
                    res_next    = '0;
                    status_next = ST_OK;
                    done_next   = 1'b0;
                    wb_next     = 1'b0;
                    state_next  = S_DONE;
                    if (req.req_type == REQ_PUSH)
                    begin
                        // push writes straight into the next free entry
                        if (stack_full)
                        begin
                            status_next = ST_OVERFLOW;
                        end
                        else
                        begin
                            mem_wr.en   = 1'b1;
                            mem_wr.addr = ADDR_W'(count_reg);
                            mem_wr.data = req.operand_value;
                            count_next  = count_reg + CNT_W'(1);
                        end
                    end
                    else if (req.req_type inside {REQ_ADD, REQ_SUB, REQ_MUL, REQ_DIV})
                    begin
                        if (count_reg < CNT_W'(2))
                        begin
                            status_next = ST_UNDERFLOW;
                        end
                        else
                        begin
                            state_next = S_OPER;
                        end
                    end
                    else if (req.req_type == REQ_EQUALS)
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_UNDERFLOW;
                        end
                        else
                        begin
                            state_next = S_OPER;
                        end
                    end
                    // unused codes fall through as an ok response with no effect
                end
            end

            S_OPER:
            begin
                state_next = S_DONE;
                case (req_reg)
                    REQ_EQUALS:
                    begin
                        res_next   = rd_data_a;
                        done_next  = 1'b1;
                        count_next = '0;
                    end
                    REQ_ADD:
                    begin
                        res_next = rd_data_b + rd_data_a;
                        wb_next  = 1'b1;
                    end
                    REQ_SUB:
                    begin
                        res_next = rd_data_b - rd_data_a;
                        wb_next  = 1'b1;
                    end
                    REQ_MUL:
                    begin
                        res_next = product;
                        wb_next  = 1'b1;
                    end
                    REQ_DIV:
                    begin
                        if (rd_data_a == '0)
                        begin
                            status_next = ST_DIVZERO;
                        end
                        else
                        begin
                            // divide magnitudes, fix the sign afterwards
                            div_start  = 1'b1;
                            neg_next   = rd_data_a[DATA_W-1] ^ rd_data_b[DATA_W-1];
                            state_next = S_DIV;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_DIV:
            begin
                if (div_stat.done)
                begin
                    res_next   = neg_reg ? (DATA_W'(0) - quotient) : quotient;
                    wb_next    = 1'b1;
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (out_load)
                begin
                    // pop two, push the result: overwrite the left operand's entry
                    if (wb_reg)
                    begin
                        mem_wr.en   = 1'b1;
                        mem_wr.addr = rd_addr_b;
                        mem_wr.data = res_reg;
                        count_next  = count_reg - CNT_W'(1);
                    end
                    wb_next    = 1'b0;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !rsp.ready;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            wb_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            wb_reg        <= wb_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        res_reg    <= res_next;
        status_reg <= status_next;
        done_reg   <= done_next;
        neg_reg    <= neg_next;
        if (out_load)
        begin
            out_value_reg  <= res_reg;
            out_status_reg <= status_reg;
            out_done_reg   <= done_reg;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.result_value    = out_value_reg;
    assign rsp.status          = out_status_reg;
    assign rsp.expression_done = out_done_reg;

    // hold the count within the stack
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    // the divider only runs while the sequencer waits for it
    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> (state_reg == S_DIV))
        else $error("divider busy outside divide state");

    // a finished equals leaves an empty stack and an ok status
    a_equals_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && done_reg) |-> (count_reg == '0 && status_reg == ST_OK))
        else $error("equals did not clear the stack");

    // no write back is pending once the sequencer is idle
    a_wb_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !wb_reg)
        else $error("write back left pending in idle");

endmodule

`default_nettype wire

>>> rtl/core/rpn_stack_mem.sv
// Stack storage: one write port, two registered read ports.
`default_nettype none

module rpn_stack_mem (
    input  wire logic                       clk,
    input  wire rpn_pkg::mem_wr_t           wr,
    input  wire logic [rpn_pkg::ADDR_W-1:0] rd_addr_a,
    input  wire logic [rpn_pkg::ADDR_W-1:0] rd_addr_b,
    output logic      [rpn_pkg::DATA_W-1:0] rd_data_a,
    output logic      [rpn_pkg::DATA_W-1:0] rd_data_b
);
    import rpn_pkg::*;

    logic [DATA_W-1:0] mem [STACK_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

`default_nettype wire

>>> rtl/core/rpn_div.sv
// Unsigned restoring divider, one quotient bit per cycle.
`default_nettype none

module rpn_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [rpn_pkg::DATA_W-1:0] dividend,
    input  wire logic [rpn_pkg::DATA_W-1:0] divisor,
    output logic      [rpn_pkg::DATA_W-1:0] quotient,
    output rpn_pkg::div_stat_t              stat
);
    import rpn_pkg::*;

    logic [DATA_W-1:0]    rem_reg, rem_next;
    logic [DATA_W-1:0]    quo_reg, quo_next;
    logic [DATA_W-1:0]    dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DATA_W:0]      shifted;
    logic [DATA_W:0]      diff;

    assign shifted = {rem_reg, quo_reg[DATA_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // keep the partial remainder when the trial subtract goes negative
            if (diff[DATA_W])
            begin
                rem_next = shifted[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            else
            begin
                rem_next = diff[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire
